FILE: sv/pbp_pkg.sv
package pbp_pkg;

   localparam int DEFAULT_MAX_BYTES = 256;
   localparam logic [8:0] PACKET_BYTES_RESET = 9'd256;

   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_NEW  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_HI,
      ST_RD_LO,
      ST_WR_LO,
      ST_GET_BYTE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic we;
      logic re;
   } ram_ctl_type;

endpackage

FILE: sv/pbp_ram.sv
module pbp_ram #(
   parameter int DEPTH = pbp_pkg::DEFAULT_MAX_BYTES,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  pbp_pkg::ram_ctl_type ctl,
   input  logic [AW-1:0]       addr,
   input  logic [7:0]          wdata,
   output logic [7:0]          rdata
);
   import pbp_pkg::*;

   logic [7:0] buffer_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         buffer_ff[addr] <= wdata;
      end
      if (ctl.re) begin
         rdata_ff <= buffer_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/packet_bit_packer_unit.sv
// Packs short bit fields, most significant bit first, into a packet buffer of
// MAX_PACKET_BYTES bytes held in a single-port memory with registered read.
// One request runs at a time under a small sequencer that shares the memory
// port and one shift/merge unit. An add reads the byte at the fill position and
// writes it back merged, and a field that straddles two bytes repeats this
// read-modify-write on the next byte. A read fetches one byte, and a refused
// or empty request goes straight to the result. A new packet clears the memory
// one byte per cycle. After reset the same pass runs before req_tready rises.
// A finished result waits in the output register while the next request is
// taken. The packet length register may be written at any time the block is idle.
module packet_bit_packer_unit #(
   parameter int MAX_PACKET_BYTES = pbp_pkg::DEFAULT_MAX_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte, bit_count, read_index, zero pad
   input  logic [1:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_byte, free_bits, overflow, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   import pbp_pkg::*;

   localparam int AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
   localparam int BW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int FW = BW + 3;

   state_type       state_ff, state_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [8:0]      packet_bytes_ff, packet_bytes_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [15:0]     win_ff, win_in;
   logic            straddle_ff, straddle_in;
   logic [7:0]      res_byte_ff, res_byte_in;
   logic            res_ovf_ff, res_ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic [11:0]     rsp_free_ff, rsp_free_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic [1:0]      req_type;
   logic [7:0]      data_byte;
   logic [3:0]      bit_count;
   logic [7:0]      read_index;

   logic [BW-1:0]   eff_bytes;
   logic [FW-1:0]   total_bits;
   logic [FW-1:0]   free_bits;
   logic            accept;
   logic            add_fail;
   logic [7:0]      masked;
   logic [4:0]      shamt;
   logic [15:0]     win;
   logic            straddle;
   logic            rd_ok;
   logic            out_free;
   logic            clr_last;

   ram_ctl_type     ram_ctl;
   logic [AW-1:0]   ram_addr;
   logic [7:0]      ram_wdata;
   logic [7:0]      ram_rdata;

   assign req_type   = req_tuser;
   assign data_byte  = req_tdata[7:0];
   assign bit_count  = req_tdata[11:8];
   assign read_index = req_tdata[19:12];

   always_comb begin
      if (32'(packet_bytes_ff) > 32'(MAX_PACKET_BYTES)) begin
         eff_bytes = BW'(MAX_PACKET_BYTES);
      end else begin
         eff_bytes = BW'(packet_bytes_ff);
      end
   end

   assign total_bits = {eff_bytes, 3'b000};
   assign free_bits  = (fill_ff >= total_bits) ? '0 : total_bits - fill_ff;

   assign accept   = req_tvalid && req_tready;
   assign add_fail = (bit_count > 4'd8) || (FW'(bit_count) > free_bits);
   assign masked   = data_byte & (8'hFF >> (4'd8 - bit_count));
   assign shamt    = 5'd16 - 5'(bit_count) - 5'(fill_ff[2:0]);
   assign win      = 16'(masked) << shamt;
   assign straddle = (5'(fill_ff[2:0]) + 5'(bit_count)) > 5'd8;
   assign rd_ok    = 32'(read_index) < 32'(eff_bytes);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign clr_last = clr_cnt_ff == AW'(MAX_PACKET_BYTES - 1);

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ovf_ff, rsp_free_ff, rsp_byte_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_ADD: begin
                     state_in = (bit_count == 4'd0 || add_fail) ? ST_DONE : ST_WR_HI;
                  end
                  REQ_NEW:  state_in = ST_CLEAR;
                  REQ_READ: state_in = rd_ok ? ST_GET_BYTE : ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_WR_HI:    state_in = straddle_ff ? ST_RD_LO : ST_DONE;
         ST_RD_LO:    state_in = ST_WR_LO;
         ST_WR_LO:    state_in = ST_DONE;
         ST_GET_BYTE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      fill_in         = fill_ff;
      packet_bytes_in = csr_valid ? csr_data : packet_bytes_ff;
      clr_cnt_in      = clr_cnt_ff;
      clr_rsp_in      = clr_rsp_ff;
      idx_in          = idx_ff;
      win_in          = win_ff;
      straddle_in     = straddle_ff;
      res_byte_in     = res_byte_ff;
      res_ovf_in      = res_ovf_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      ram_ctl         = '{we: 1'b0, re: 1'b0};
      ram_addr        = idx_ff;
      ram_wdata       = 8'h00;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_ctl.we = 1'b1;
            ram_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            res_byte_in = 8'h00;
            res_ovf_in  = 1'b0;
            idx_in      = AW'(fill_ff[FW-1:3]);
            win_in      = win;
            straddle_in = straddle;
            ram_addr    = (req_type == REQ_READ) ? AW'(read_index) : AW'(fill_ff[FW-1:3]);
            if (accept) begin
               unique case (req_type)
                  REQ_ADD: begin
                     if (bit_count != 4'd0) begin
                        res_ovf_in = add_fail;
                        if (!add_fail) begin
                           ram_ctl.re = 1'b1;
                           fill_in    = fill_ff + FW'(bit_count);
                        end
                     end
                  end
                  REQ_NEW: begin
                     fill_in    = '0;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  REQ_READ: begin
                     res_ovf_in = !rd_ok;
                     ram_ctl.re = rd_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WR_HI: begin
            ram_ctl.we = 1'b1;
            ram_wdata  = ram_rdata | win_ff[15:8];
         end
         ST_RD_LO: begin
            ram_ctl.re = 1'b1;
            ram_addr   = idx_ff + AW'(1);
         end
         ST_WR_LO: begin
            ram_ctl.we = 1'b1;
            ram_addr   = idx_ff + AW'(1);
            ram_wdata  = ram_rdata | win_ff[7:0];
         end
         ST_GET_BYTE: begin
            res_byte_in = ram_rdata;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_byte_ff;
               rsp_free_in  = 12'(free_bits);
               rsp_ovf_in   = res_ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         fill_ff         <= '0;
         packet_bytes_ff <= PACKET_BYTES_RESET;
         clr_cnt_ff      <= '0;
         clr_rsp_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fill_ff         <= fill_in;
         packet_bytes_ff <= packet_bytes_in;
         clr_cnt_ff      <= clr_cnt_in;
         clr_rsp_ff      <= clr_rsp_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      win_ff      <= win_in;
      straddle_ff <= straddle_in;
      res_byte_ff <= res_byte_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_free_ff <= rsp_free_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   pbp_ram #(
      .DEPTH (MAX_PACKET_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

FILE: verif/tb_packet_bit_packer_unit.sv
`timescale 1ns / 100ps

module tb_packet_bit_packer_unit;
   import pbp_pkg::*;

   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int MAX_BYTES = DEFAULT_MAX_BYTES;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;
   int requests_sent;
   int length_writes;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic [11:0] free_bits;
      logic        overflow;
   } pack_rsp_type;

   class bit_packer_model;
      bit [7:0]     packet_mem [MAX_BYTES];
      int unsigned  fill_pos;
      bit [8:0]     length_reg;
      pack_rsp_type responses_due [$];
      int           errors;
      int           checked;
      int           refusals;

      function new();
         foreach (packet_mem[i]) packet_mem[i] = 8'h00;
         fill_pos = 0;
         length_reg = PACKET_BYTES_RESET;
         errors = 0;
         checked = 0;
         refusals = 0;
      endfunction

      function int unsigned eff_bytes();
         return (32'(length_reg) > MAX_BYTES) ? MAX_BYTES : 32'(length_reg);
      endfunction

      function int unsigned free_count();
         int unsigned total;
         total = eff_bytes() * 8;
         return (fill_pos >= total) ? 0 : total - fill_pos;
      endfunction

      function int pending();
         return responses_due.size();
      endfunction

      function void set_length(bit [8:0] v);
         length_reg = v;
      endfunction

      function bit append_field(int unsigned data, int unsigned n);
         int unsigned bits;
         int unsigned idx;
         int unsigned off;
         if (n == 0) return 1'b0;
         if (n > 8 || n > free_count()) return 1'b1;
         bits = data & (8'hFF >> (8 - n));
         idx = fill_pos / 8;
         off = fill_pos % 8;
         if (off + n <= 8) begin
            packet_mem[idx] = packet_mem[idx] | 8'(bits << (8 - n - off));
         end else begin
            packet_mem[idx] = packet_mem[idx] | 8'(bits >> (n + off - 8));
            packet_mem[idx + 1] = packet_mem[idx + 1] | 8'(bits << (16 - n - off));
         end
         fill_pos = fill_pos + n;
         return 1'b0;
      endfunction

      function void apply_request(logic [1:0] kind, logic [7:0] data, logic [3:0] cnt,
                                  logic [7:0] idx);
         pack_rsp_type r;
         r = '0;
         case (kind)
            REQ_ADD: begin
               r.overflow = append_field(32'(data), 32'(cnt));
            end
            REQ_NEW: begin
               foreach (packet_mem[i]) packet_mem[i] = 8'h00;
               fill_pos = 0;
            end
            REQ_READ: begin
               if (32'(idx) < eff_bytes()) r.read_byte = packet_mem[idx];
               else r.overflow = 1'b1;
            end
            default: ;
         endcase
         r.free_bits = 12'(free_count());
         responses_due.push_back(r);
      endfunction

      function void report(string what, int exp_v, int act_v);
         errors++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
      endfunction

      function void compare_response(logic [23:0] word);
         pack_rsp_type e;
         if (responses_due.size() == 0) begin
            report("unexpected response, data", 0, 32'(word));
            return;
         end
         e = responses_due.pop_front();
         checked++;
         if (e.overflow) refusals++;
         if (word[7:0] !== e.read_byte)
            report("read_byte", 32'(e.read_byte), 32'(word[7:0]));
         if (word[19:8] !== e.free_bits)
            report("free_bits", 32'(e.free_bits), 32'(word[19:8]));
         if (word[20] !== e.overflow)
            report("overflow", 32'(e.overflow), 32'(word[20]));
      endfunction
   endclass

   bit_packer_model model;

   packet_bit_packer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_packet_bit_packer_unit: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.compare_response(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_req(input logic [1:0] kind, input logic [7:0] data,
                           input logic [3:0] cnt, input logic [7:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, idx, cnt, data};
      do @(posedge clock); while (!req_tready);
      model.apply_request(kind, data, cnt, idx);
      requests_sent++;
   endtask

   task automatic write_length(input logic [8:0] v);
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model.set_length(v);
      length_writes++;
   endtask

   task automatic random_req();
      int unsigned eff;
      int unsigned r;
      int unsigned add_w;
      logic [3:0]  cnt;
      logic [7:0]  data;
      logic [7:0]  idx;
      eff = model.eff_bytes();
      r = $urandom_range(0, 99);
      add_w = (eff >= 128) ? 78 : 62;
      data = 8'($urandom_range(0, 255));
      idx = 8'($urandom_range(0, 255));
      cnt = 4'($urandom_range(0, 15));
      if ((model.free_count() == 0 && $urandom_range(0, 3) == 0) || r < 2) begin
         send_req(REQ_NEW, data, cnt, idx);
      end else if (r < add_w) begin
         cnt = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(1, 8));
         send_req(REQ_ADD, data, cnt, idx);
      end else if (r < add_w + 12) begin
         if (eff > 0) idx = 8'($urandom_range(0, eff - 1));
         send_req(REQ_READ, data, cnt, idx);
      end else if (r < add_w + 16) begin
         send_req(REQ_READ, data, cnt, idx);
      end else if (r < add_w + 19) begin
         cnt = 4'($urandom_range(0, 7));
         if (cnt != 0) cnt = cnt + 4'd8;
         send_req(REQ_ADD, data, cnt, idx);
      end else begin
         send_req(REQ_SPARE, data, cnt, idx);
      end
   endtask

   int phase_len [15]  = '{256, 1, 4, 0, 511, 16, 2, 257, 3, 8, 255, 6, 1, 64, 5};
   int phase_cnt [15]  = '{400, 60, 80, 40, 100, 120, 60, 100, 80, 120, 240, 90, 60, 120, 80};
   bit phase_keep [15] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0};

   initial begin
      model = new();
      cycle_count = 0;
      requests_sent = 0;
      length_writes = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= REQ_ADD;
      rsp_tready <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset length, straddling fields, bad counts, spare code
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      send_req(REQ_ADD, 8'hFF, 4'd0, 8'd0);
      send_req(REQ_ADD, 8'hFF, 4'd8, 8'd0);
      send_req(REQ_ADD, 8'hFD, 4'd3, 8'd0);
      send_req(REQ_ADD, 8'h7F, 4'd7, 8'd0);
      send_req(REQ_ADD, 8'hFF, 4'd9, 8'd0);
      send_req(REQ_ADD, 8'hFF, 4'd15, 8'hFF);
      send_req(REQ_SPARE, 8'hFF, 4'd15, 8'hFF);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd1);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd2);
      send_req(REQ_READ, 8'hFF, 4'd15, 8'd255);
      send_req(REQ_ADD, 8'h00, 4'd8, 8'd0);
      send_req(REQ_ADD, 8'hFE, 4'd1, 8'd0);
      send_req(REQ_ADD, 8'h1F, 4'd5, 8'd0);
      send_req(REQ_NEW, 8'hFF, 4'd8, 8'd255);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      send_req(REQ_ADD, 8'h01, 4'd1, 8'd0);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      // one-byte packet, then zero length
      write_length(9'd1);
      send_req(REQ_ADD, 8'hA5, 4'd8, 8'd0);
      send_req(REQ_ADD, 8'h01, 4'd1, 8'd0);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd1);
      write_length(9'd0);
      send_req(REQ_ADD, 8'h01, 4'd1, 8'd0);
      send_req(REQ_READ, 8'h00, 4'd0, 8'd0);
      send_req(REQ_ADD, 8'h01, 4'd0, 8'd0);

      for (int p = 0; p < 15; p++) begin
         write_length(9'(phase_len[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         if (!phase_keep[p]) send_req(REQ_NEW, 8'($urandom_range(0, 255)), 4'd0, 8'd0);
         for (int i = 0; i < phase_cnt[p]; i++) random_req();
      end

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (model.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests across %0d packet length writes", requests_sent,
               length_writes);
      $display("%0d responses checked, %0d refused adds or reads", model.checked,
               model.refusals);
      if (model.errors == 0 && model.pending() == 0) begin
         $display("tb_packet_bit_packer_unit: clean");
      end else begin
         $display("tb_packet_bit_packer_unit: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/pbp_pkg.sv
sv/pbp_ram.sv
sv/packet_bit_packer_unit.sv
verif/tb_packet_bit_packer_unit.sv
